[sv/one_shot_timer_table_top_assert.svh]
// assertion macros for the one-shot timer table
`ifndef ONE_SHOT_TIMER_TABLE_TOP_ASSERT_SVH
`define ONE_SHOT_TIMER_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define OSTT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer table check failed");

// next-cycle implication, disabled while reset is asserted
`define OSTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

[sv/ostt_pkg.sv]
// shared types and constants of the one-shot timer table
`timescale 1ns / 1ps

package ostt_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned HANDLE_BITS_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // fixed field widths on the stream ports
  localparam int unsigned FIELD_HANDLE_W = 8;
  localparam int unsigned FIELD_TARGET_W = 16;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned IN_DATA_W      = 32;
  localparam int unsigned OUT_DATA_W     = 16;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_ADD  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FIRED = 3'd0,
    ST_NONE  = 3'd1,
    ST_ADDED = 3'd2,
    ST_FULL  = 3'd3,
    ST_ZERO  = 3'd4
  } status_e;

endpackage

[sv/ostt_cell.sv]
// one timer slot of the rotating ring
`timescale 1ns / 1ps

module ostt_cell #(
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic                   live_i,
  input  logic [COUNT_BITS-1:0]  elapsed_i,
  input  logic [COUNT_BITS-1:0]  goal_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  input  logic                   kind_i,
  output logic                   live_o,
  output logic [COUNT_BITS-1:0]  elapsed_o,
  output logic [COUNT_BITS-1:0]  goal_o,
  output logic [HANDLE_BITS-1:0] handle_o,
  output logic                   kind_o
);

  logic                   live_q;
  logic [COUNT_BITS-1:0]  elapsed_q;
  logic [COUNT_BITS-1:0]  goal_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (shift_i) begin
      live_q <= live_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      elapsed_q <= elapsed_i;
      goal_q    <= goal_i;
      handle_q  <= handle_i;
      kind_q    <= kind_i;
    end
  end

  assign live_o    = live_q;
  assign elapsed_o = elapsed_q;
  assign goal_o    = goal_q;
  assign handle_o  = handle_q;
  assign kind_o    = kind_q;

endmodule

[sv/one_shot_timer_table_top.sv]
// top level of the one-shot timer table
//
// Requests arrive on the s_axis channel: tuser selects tick (0) or add (1),
// tdata carries handle, kind and target ticks of an add. Results leave on
// m_axis: tuser is the status, tdata the fired handle and kind, tlast marks
// the final result caused by a request.
// The slots sit in a ring of cells that rotates by one position per cycle
// while a request is walked. Every request walks the whole ring once: the
// cell at the head is updated (tick: count up and test for expiry; add: the
// first free slot takes the new timer) and re-enters at the tail, so after
// TIMER_SLOTS steps the ring is back in slot order. The final result is
// then written to the output register. A request is not accepted while
// another is walked; the next request is taken the cycle after the walk
// ends. Fired results leave one by one during the walk, in slot order,
// through an output register; a single held result lets tlast be set on
// the final one. When the receiver stalls with a result in the output
// register, the ring stops and resumes once the result is taken. A finished
// result may wait in the output register while the next request is
// accepted. Reset clears all slots at once; no clearing pass is needed.
`timescale 1ns / 1ps

module one_shot_timer_table_top
  import ostt_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] flag_handle, [8] flag_kind, [24:9] target_ticks, [31:25] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] cmd
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] fired_handle, [8] fired_kind, [15:9] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [2:0] status
  output logic [STATUS_W-1:0]   m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);

  // ring of cells
  logic                   cell_live    [TIMER_SLOTS];
  logic [COUNT_BITS-1:0]  cell_elapsed [TIMER_SLOTS];
  logic [COUNT_BITS-1:0]  cell_goal    [TIMER_SLOTS];
  logic [HANDLE_BITS-1:0] cell_handle  [TIMER_SLOTS];
  logic                   cell_kind    [TIMER_SLOTS];

  logic                   tail_live;
  logic [COUNT_BITS-1:0]  tail_elapsed;
  logic [COUNT_BITS-1:0]  tail_goal;
  logic [HANDLE_BITS-1:0] tail_handle;
  logic                   tail_kind;

  // request being walked
  logic                   busy_q;
  logic [CNT_W-1:0]       cnt_q;
  cmd_e                   cmd_q;
  logic [HANDLE_BITS-1:0] new_handle_q;
  logic                   new_kind_q;
  logic [COUNT_BITS-1:0]  new_goal_q;
  logic                   zero_q;
  logic                   placed_q;

  // held fired result
  logic                   pend_valid_q;
  logic [HANDLE_BITS-1:0] pend_handle_q;
  logic                   pend_kind_q;

  // output register
  logic                      out_valid_q;
  status_e                   out_status_q;
  logic [FIELD_HANDLE_W-1:0] out_handle_q;
  logic                      out_kind_q;
  logic                      out_last_q;

  logic                  in_accept;
  logic                  in_zero;
  logic                  can_push;
  logic                  walk_done;
  logic                  step;
  logic                  finish;
  logic                  head_tick;
  logic [COUNT_BITS-1:0] head_next;
  logic                  head_fire;
  logic                  head_write;
  logic                  push;
  status_e               push_status;
  logic [HANDLE_BITS-1:0] push_handle;
  logic                  push_kind;
  logic                  push_last;

  assign s_axis_tready_o = !busy_q;
  assign in_accept       = s_axis_tvalid_i && !busy_q;
  assign in_zero = (COUNT_BITS'(s_axis_tdata_i[FIELD_HANDLE_W+1 +: FIELD_TARGET_W])
                    == '0);

  assign can_push  = !out_valid_q || m_axis_tready_i;
  assign walk_done = (cnt_q == CNT_W'(TIMER_SLOTS));
  assign step      = busy_q && can_push && !walk_done;
  assign finish    = busy_q && can_push && walk_done;

  // head cell update
  assign head_tick  = (cmd_q == CMD_TICK) && cell_live[0];
  assign head_next  = cell_elapsed[0] + COUNT_BITS'(1);
  assign head_fire  = head_tick && (head_next == cell_goal[0]);
  assign head_write = (cmd_q == CMD_ADD) && !placed_q && !cell_live[0];

  always_comb begin
    tail_live    = cell_live[0];
    tail_elapsed = cell_elapsed[0];
    tail_goal    = cell_goal[0];
    tail_handle  = cell_handle[0];
    tail_kind    = cell_kind[0];
    if (head_write) begin
      tail_live    = 1'b1;
      tail_elapsed = '0;
      tail_goal    = new_goal_q;
      tail_handle  = new_handle_q;
      tail_kind    = new_kind_q;
    end else if (head_tick) begin
      tail_live    = !head_fire;
      tail_elapsed = head_next;
    end
  end

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_ring
    logic                   nxt_live;
    logic [COUNT_BITS-1:0]  nxt_elapsed;
    logic [COUNT_BITS-1:0]  nxt_goal;
    logic [HANDLE_BITS-1:0] nxt_handle;
    logic                   nxt_kind;

    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign nxt_live    = tail_live;
      assign nxt_elapsed = tail_elapsed;
      assign nxt_goal    = tail_goal;
      assign nxt_handle  = tail_handle;
      assign nxt_kind    = tail_kind;
    end else begin : g_mid
      assign nxt_live    = cell_live[i+1];
      assign nxt_elapsed = cell_elapsed[i+1];
      assign nxt_goal    = cell_goal[i+1];
      assign nxt_handle  = cell_handle[i+1];
      assign nxt_kind    = cell_kind[i+1];
    end

    ostt_cell #(
      .COUNT_BITS (COUNT_BITS),
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (step),
      .live_i   (nxt_live),
      .elapsed_i(nxt_elapsed),
      .goal_i   (nxt_goal),
      .handle_i (nxt_handle),
      .kind_i   (nxt_kind),
      .live_o   (cell_live[i]),
      .elapsed_o(cell_elapsed[i]),
      .goal_o   (cell_goal[i]),
      .handle_o (cell_handle[i]),
      .kind_o   (cell_kind[i])
    );
  end

  // result selection: a new expiry pushes out the held one, the walk end
  // pushes the final result
  always_comb begin
    push        = 1'b0;
    push_status = ST_NONE;
    push_handle = '0;
    push_kind   = 1'b0;
    push_last   = 1'b1;
    if (step && head_fire && pend_valid_q) begin
      push        = 1'b1;
      push_status = ST_FIRED;
      push_handle = pend_handle_q;
      push_kind   = pend_kind_q;
      push_last   = 1'b0;
    end else if (finish) begin
      push = 1'b1;
      if (cmd_q == CMD_TICK) begin
        if (pend_valid_q) begin
          push_status = ST_FIRED;
          push_handle = pend_handle_q;
          push_kind   = pend_kind_q;
        end else begin
          push_status = ST_NONE;
        end
      end else if (zero_q) begin
        push_status = ST_ZERO;
      end else if (placed_q) begin
        push_status = ST_ADDED;
      end else begin
        push_status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      placed_q     <= 1'b0;
      zero_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        zero_q   <= (cmd_e'(s_axis_tuser_i) == CMD_ADD) && in_zero;
        // a refused add must not claim a slot
        placed_q <= in_zero;
      end else if (step) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (head_write) begin
          placed_q <= 1'b1;
        end
      end else if (finish) begin
        busy_q <= 1'b0;
      end

      if (finish) begin
        pend_valid_q <= 1'b0;
      end else if (step && head_fire) begin
        pend_valid_q <= 1'b1;
      end

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q        <= cmd_e'(s_axis_tuser_i);
      new_handle_q <= HANDLE_BITS'(s_axis_tdata_i[FIELD_HANDLE_W-1:0]);
      new_kind_q   <= s_axis_tdata_i[FIELD_HANDLE_W];
      new_goal_q   <= COUNT_BITS'(s_axis_tdata_i[FIELD_HANDLE_W+1 +: FIELD_TARGET_W]);
    end
    if (step && head_fire) begin
      pend_handle_q <= cell_handle[0];
      pend_kind_q   <= cell_kind[0];
    end
    if (push) begin
      out_status_q <= push_status;
      out_handle_q <= FIELD_HANDLE_W'(push_handle);
      out_kind_q   <= push_kind;
      out_last_q   <= push_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - FIELD_HANDLE_W - 1)'(0), out_kind_q, out_handle_q};

  `include "one_shot_timer_table_top_assert.svh"

  `OSTT_ASSERT_NEXT(a_accept_starts_walk, in_accept, busy_q && (cnt_q == '0))
  `OSTT_ASSERT_NEXT(a_finish_ends_request, finish,
                    !busy_q && m_axis_tvalid_o && m_axis_tlast_o)
  `OSTT_ASSERT_NOW(a_pend_only_in_walk, pend_valid_q, busy_q && (cmd_q == CMD_TICK))
  `OSTT_ASSERT_NOW(a_no_push_on_full_output, push, can_push)

endmodule
